// ===== design/fiq_pkg.sv =====
// Shared constants and controller/datapath interface types for the fair interleave queue.
`timescale 1ns / 1ps

package fiq_pkg;

   localparam int DEF_QUEUE_DEPTH = 32;

   localparam int OP_W    = 2;
   localparam int VOICE_W = 4;
   localparam int OCC_W   = 6;
   localparam int SET_W   = 1 << VOICE_W;

   localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
   localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE  = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

   // controller -> datapath
   typedef struct packed {
      logic load;     // latch request, reset pass counters
      logic scan;     // stream one entry per cycle into the other bank, pausing at the insertion slot
      logic tail;     // append voice at the end of the new bank
      logic commit;   // swap banks, update entry count (clear: zero the count; dropped enqueue: no change)
   } fiq_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic scan_done;
      logic need_tail;
   } fiq_stat_type;

endpackage

// ===== design/fair_interleave_request_queue.sv =====
// Top level of the fair interleave request queue: controller plus datapath.
`timescale 1ns / 1ps

// Ordered queue of 4-bit voice numbers that interleaves requesters fairly.
// Each request transaction (enqueue, dequeue, remove-all-of-voice, clear)
// yields exactly one response transaction carrying the popped voice, a pop
// flag, a drop flag for an enqueue into a full queue, and the occupancy
// after the operation (modulo 64). One transaction is in flight at a time:
// req_stall is high from acceptance until the response is taken. Enqueue,
// dequeue and remove rewrite the queue in a single streaming pass that reads
// the live bank of the entry memory through its one read port, one entry per
// cycle but for a pause at the insertion slot, and writes the result into
// the other bank; the banks then swap. An enqueue that finds no insertion
// slot appends the voice at the tail after the pass. Clear and a dropped
// enqueue skip the pass. The next request is accepted in the cycle after
// the response is taken. The entry memory needs no clearing after reset.

module fair_interleave_request_queue #(
   parameter int QUEUE_DEPTH = fiq_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [fiq_pkg::OP_W-1:0]       req_op,
   input  logic [fiq_pkg::VOICE_W-1:0]    req_voice,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [fiq_pkg::VOICE_W-1:0]    rsp_out_voice,
   output logic                           rsp_out_valid,
   output logic                           rsp_dropped,
   output logic [fiq_pkg::OCC_W-1:0]      rsp_occupancy
);

   fiq_pkg::fiq_cmd_type  cmd;
   fiq_pkg::fiq_stat_type stat;

   // sequencing: accept -> [scan pass] -> [tail append] -> commit -> respond
   fiq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // entry storage and the streaming insert/remove logic
   fiq_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_op        (req_op),
      .req_voice     (req_voice),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_out_voice (rsp_out_voice),
      .rsp_out_valid (rsp_out_valid),
      .rsp_dropped   (rsp_dropped),
      .rsp_occupancy (rsp_occupancy)
   );

endmodule

// ===== design/fiq_ctrl.sv =====
// Controller state machine: request/response handshake and pass sequencing.
`timescale 1ns / 1ps

module fiq_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [fiq_pkg::OP_W-1:0]    req_op,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  fiq_pkg::fiq_stat_type       stat,
   output fiq_pkg::fiq_cmd_type        cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_TAIL   = 3'd2;
   localparam logic [2:0] ST_COMMIT = 3'd3;
   localparam logic [2:0] ST_RESP   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;
   logic       skip_scan;

   assign accept    = (state_ff == ST_IDLE) && req_valid;
   // clear and a full-queue enqueue need no pass over the entries
   assign skip_scan = (req_op == fiq_pkg::OP_CLEAR) ||
                      ((req_op == fiq_pkg::OP_ENQUEUE) && stat.full);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = skip_scan ? ST_COMMIT : ST_SCAN;
         end
         ST_SCAN: begin
            if (stat.scan_done) state_in = stat.need_tail ? ST_TAIL : ST_COMMIT;
         end
         ST_TAIL:   state_in = ST_COMMIT;
         ST_COMMIT: state_in = ST_RESP;
         ST_RESP: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = (state_ff == ST_RESP);
   assign cmd.load   = accept;
   assign cmd.scan   = (state_ff == ST_SCAN);
   assign cmd.tail   = (state_ff == ST_TAIL);
   assign cmd.commit = (state_ff == ST_COMMIT);

endmodule

// ===== design/fiq_dp.sv =====
// Datapath: two-bank entry memory, streaming copy with insert/remove, result registers.
`timescale 1ns / 1ps

module fiq_dp #(
   parameter int QUEUE_DEPTH = fiq_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [fiq_pkg::OP_W-1:0]       req_op,
   input  logic [fiq_pkg::VOICE_W-1:0]    req_voice,
   input  fiq_pkg::fiq_cmd_type           cmd,
   output fiq_pkg::fiq_stat_type          stat,
   output logic [fiq_pkg::VOICE_W-1:0]    rsp_out_voice,
   output logic                           rsp_out_valid,
   output logic                           rsp_dropped,
   output logic [fiq_pkg::OCC_W-1:0]      rsp_occupancy
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int VW    = fiq_pkg::VOICE_W;
   localparam int SW    = fiq_pkg::SET_W;

   // bank_ff holds the live queue, the other bank receives the rewritten copy
   logic [VW-1:0]    slot_voice_ff [2][QUEUE_DEPTH];
   logic [VW-1:0]    rd_data_ff;

   logic [fiq_pkg::OP_W-1:0] op_ff;
   logic [VW-1:0]    voice_ff;

   logic             bank_ff,     bank_in;
   logic [CNT_W-1:0] count_ff,    count_in;
   logic [CNT_W-1:0] rd_cnt_ff,   rd_cnt_in;
   logic [CNT_W-1:0] wr_cnt_ff,   wr_cnt_in;
   logic             data_vld_ff, data_vld_in;
   logic [SW-1:0]    run_ff,      run_in;
   logic             ins_done_ff, ins_done_in;
   logic             head_ff,     head_in;
   logic             drop_ff,     drop_in;
   logic             pop_vld_ff,  pop_vld_in;
   logic [VW-1:0]    pop_voice_ff, pop_voice_in;

   logic          is_enq, is_deq, is_rem;
   logic [SW-1:0] cur_bit, want_bit;
   logic          ins_now, consume, rd_en, wr_en;
   logic [VW-1:0] wr_data;

   assign is_enq   = (op_ff == fiq_pkg::OP_ENQUEUE);
   assign is_deq   = (op_ff == fiq_pkg::OP_DEQUEUE);
   assign is_rem   = (op_ff == fiq_pkg::OP_REMOVE);
   assign cur_bit  = SW'(1) << rd_data_ff;
   assign want_bit = SW'(1) << voice_ff;

   // current entry would close its run and the run lacks the voice: insert here
   assign ins_now = cmd.scan && is_enq && !ins_done_ff && data_vld_ff &&
                    ((run_ff & cur_bit) != '0) && ((run_ff & want_bit) == '0);
   assign consume = cmd.scan && data_vld_ff && !ins_now;
   assign rd_en   = cmd.scan && (rd_cnt_ff < count_ff) && (!data_vld_ff || consume);

   always_comb begin
      wr_en = 1'b0;
      if (cmd.tail) begin
         wr_en = 1'b1;
      end else if (cmd.scan && data_vld_ff) begin
         if (is_enq)      wr_en = 1'b1;
         else if (is_rem) wr_en = (rd_data_ff != voice_ff);
         else if (is_deq) wr_en = !head_ff;
      end
   end

   assign wr_data = (ins_now || cmd.tail) ? voice_ff : rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) slot_voice_ff[~bank_ff][wr_cnt_ff[IDX_W-1:0]] <= wr_data;
      if (rd_en) rd_data_ff <= slot_voice_ff[bank_ff][rd_cnt_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_op;
         voice_ff <= req_voice;
      end
   end

   always_comb begin
      bank_in      = bank_ff;
      count_in     = count_ff;
      rd_cnt_in    = rd_cnt_ff + CNT_W'(rd_en);
      wr_cnt_in    = wr_cnt_ff + CNT_W'(wr_en);
      data_vld_in  = rd_en ? 1'b1 : (consume ? 1'b0 : data_vld_ff);
      run_in       = run_ff;
      ins_done_in  = ins_done_ff | ins_now;
      head_in      = head_ff;
      drop_in      = drop_ff;
      pop_vld_in   = pop_vld_ff;
      pop_voice_in = pop_voice_ff;

      if (consume) begin
         head_in = 1'b0;
         run_in  = ((run_ff & cur_bit) != '0) ? cur_bit : (run_ff | cur_bit);
         if (is_deq && head_ff) begin
            pop_vld_in   = 1'b1;
            pop_voice_in = rd_data_ff;
         end
      end

      if (cmd.load) begin
         rd_cnt_in    = '0;
         wr_cnt_in    = '0;
         data_vld_in  = 1'b0;
         run_in       = '0;
         ins_done_in  = 1'b0;
         head_in      = 1'b1;
         drop_in      = (req_op == fiq_pkg::OP_ENQUEUE) && stat.full;
         pop_vld_in   = 1'b0;
         pop_voice_in = '0;
      end

      if (cmd.commit) begin
         if (op_ff == fiq_pkg::OP_CLEAR) begin
            count_in = '0;
         end else if (!drop_ff) begin
            bank_in  = ~bank_ff;
            count_in = wr_cnt_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff      <= 1'b0;
         count_ff     <= '0;
         rd_cnt_ff    <= '0;
         wr_cnt_ff    <= '0;
         data_vld_ff  <= 1'b0;
         ins_done_ff  <= 1'b0;
         head_ff      <= 1'b0;
         drop_ff      <= 1'b0;
         pop_vld_ff   <= 1'b0;
         pop_voice_ff <= '0;
      end else begin
         bank_ff      <= bank_in;
         count_ff     <= count_in;
         rd_cnt_ff    <= rd_cnt_in;
         wr_cnt_ff    <= wr_cnt_in;
         data_vld_ff  <= data_vld_in;
         ins_done_ff  <= ins_done_in;
         head_ff      <= head_in;
         drop_ff      <= drop_in;
         pop_vld_ff   <= pop_vld_in;
         pop_voice_ff <= pop_voice_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in;
   end

   assign stat.full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign stat.scan_done = (rd_cnt_ff == count_ff) && !data_vld_ff;
   assign stat.need_tail = is_enq && !ins_done_ff;

   assign rsp_out_voice = pop_voice_ff;
   assign rsp_out_valid = pop_vld_ff;
   assign rsp_dropped   = drop_ff;
   assign rsp_occupancy = fiq_pkg::OCC_W'(count_ff);

endmodule

// ===== dv/fair_interleave_request_queue_tb.sv =====
// Testbench for the fair interleave request queue: directed table, random traffic, self-check.
`timescale 1ns / 1ps

module fair_interleave_request_queue_tb;

   localparam int QUEUE_DEPTH  = fiq_pkg::DEF_QUEUE_DEPTH;
   localparam int RANDOM_ITEMS = 785;
   localparam int DRAIN_CYCLES = 60;    // margin beyond the longest pass

   // One response transaction as the block reports it.
   typedef struct packed {
      logic [fiq_pkg::VOICE_W-1:0] voice;
      logic                        popped;
      logic                        dropped;
      logic [fiq_pkg::OCC_W-1:0]   occupancy;
   } voice_response_type;

   // One row of the directed table. A row may repeat; with walk set the
   // voice advances by one on each repeat. Rows with typed set carry the
   // response spelled out by hand, the rest go through the shadow queue.
   typedef struct packed {
      logic [fiq_pkg::OP_W-1:0]    op;
      logic [fiq_pkg::VOICE_W-1:0] voice;
      logic [5:0]                  count;
      logic                        walk;
      logic                        typed;
      voice_response_type          want;
   } stim_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [fiq_pkg::OP_W-1:0]      req_op = fiq_pkg::OP_DEQUEUE;
   logic [fiq_pkg::VOICE_W-1:0]   req_voice = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [fiq_pkg::VOICE_W-1:0]   rsp_out_voice;
   logic                          rsp_out_valid;
   logic                          rsp_dropped;
   logic [fiq_pkg::OCC_W-1:0]     rsp_occupancy;

   // Shadow copy of the queue contents, head at index 0.
   logic [fiq_pkg::VOICE_W-1:0]   shadow_voices[$];
   // Responses still owed by the block, oldest first.
   voice_response_type            awaited_responses[$];
   stim_row_type                  directed_rows[$];

   int                   mismatches = 0;
   int                   responses_seen = 0;
   int                   burst_left = 0;

   fair_interleave_request_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_voice     (req_voice),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_voice (rsp_out_voice),
      .rsp_out_valid (rsp_out_valid),
      .rsp_dropped   (rsp_dropped),
      .rsp_occupancy (rsp_occupancy)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Run limit: far beyond the slowest legal run (about 850 transactions,
   // each with its pass plus the longest stall and gap).
   initial begin
      #1000000;
      $display("fair_interleave_request_queue_tb failed");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("%0t ns: response %0d %s: got %0d, expected %0d",
               $time, responses_seen, what, got, want);
   endtask

   // Shadow queue update for one request; returns the response it owes.
   function automatic voice_response_type update_voice_queue(
         input logic [fiq_pkg::OP_W-1:0]    op,
         input logic [fiq_pkg::VOICE_W-1:0] voice);
      voice_response_type        result;
      logic [fiq_pkg::SET_W-1:0] run_set;
      logic [fiq_pkg::SET_W-1:0] want_bit;
      logic [fiq_pkg::SET_W-1:0] entry_bit;
      int                        slot;
      int                        i;
      bit                        found;

      result = '0;
      case (op)
         fiq_pkg::OP_ENQUEUE: begin
            if (shadow_voices.size() >= QUEUE_DEPTH) begin
               result.dropped = 1'b1;
            end else begin
               // Walk the runs from the head; a run closes where a voice
               // repeats. The first closed run lacking this voice takes it.
               want_bit = fiq_pkg::SET_W'(1) << voice;
               run_set  = '0;
               slot     = shadow_voices.size();
               found    = 1'b0;
               for (i = 0; i < shadow_voices.size() && !found; i++) begin
                  entry_bit = fiq_pkg::SET_W'(1) << shadow_voices[i];
                  if ((run_set & entry_bit) != '0) begin
                     if ((run_set & want_bit) == '0) begin
                        slot  = i;
                        found = 1'b1;
                     end
                     run_set = '0;
                  end
                  run_set |= entry_bit;
               end
               shadow_voices.insert(slot, voice);
            end
         end
         fiq_pkg::OP_DEQUEUE: begin
            if (shadow_voices.size() > 0) begin
               result.voice  = shadow_voices.pop_front();
               result.popped = 1'b1;
            end
         end
         fiq_pkg::OP_REMOVE: begin
            for (i = shadow_voices.size() - 1; i >= 0; i--)
               if (shadow_voices[i] == voice)
                  shadow_voices.delete(i);
         end
         fiq_pkg::OP_CLEAR: begin
            shadow_voices.delete();
         end
      endcase
      result.occupancy = fiq_pkg::OCC_W'(shadow_voices.size());
      return result;
   endfunction

   function automatic stim_row_type make_row(input logic [fiq_pkg::OP_W-1:0] op,
                                             input logic [fiq_pkg::VOICE_W-1:0] voice,
                                             input int count, input bit walk,
                                             input bit typed,
                                             input voice_response_type want);
      stim_row_type row;
      row.op    = op;
      row.voice = voice;
      row.count = 6'(count);
      row.walk  = walk;
      row.typed = typed;
      row.want  = want;
      return row;
   endfunction

   function automatic voice_response_type resp(input int voice, input bit popped,
                                               input bit dropped, input int occupancy);
      voice_response_type r;
      r.voice     = fiq_pkg::VOICE_W'(voice);
      r.popped    = popped;
      r.dropped   = dropped;
      r.occupancy = fiq_pkg::OCC_W'(occupancy);
      return r;
   endfunction

   // Drive one request transaction and hold it until accepted. The shadow
   // queue is advanced at the accepting edge; a hand-typed response, when
   // given, replaces the computed one in the awaited list. After the
   // transaction the sender either keeps valid up (inside a burst) or drops
   // it for a random gap.
   task automatic send_request(input logic [fiq_pkg::OP_W-1:0] op,
                               input logic [fiq_pkg::VOICE_W-1:0] voice,
                               input bit typed, input voice_response_type want);
      voice_response_type predicted;

      req_op    <= op;
      req_voice <= voice;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predicted = update_voice_queue(op, voice);
      awaited_responses.push_back(typed ? want : predicted);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         // Mostly short bursts, now and then a long stretch without gaps.
         burst_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(20, 60))
                                                   : int'($urandom_range(0, 6));
      end else begin
         burst_left--;
      end
   endtask

   // Response side: stall pattern in modes that change at random intervals
   // (no stall, scattered stalls, long on/off runs), and the check
   // of each accepted response against the oldest awaited one.
   int                 stall_mode = 0;
   int                 mode_left = 0;
   int                 hold_left = 0;
   voice_response_type oldest;

   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= int'($urandom_range(0, 2));
         mode_left  <= int'($urandom_range(50, 300));
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: begin
            if (hold_left != 0) begin
               hold_left <= hold_left - 1;
            end else begin
               rsp_stall <= !rsp_stall;
               hold_left <= int'($urandom_range(0, 11));
            end
         end
      endcase

      if (!reset && rsp_valid && !rsp_stall) begin
         responses_seen++;
         if (awaited_responses.size() == 0) begin
            report_mismatch("unexpected transaction, occupancy", int'(rsp_occupancy), 0);
         end else begin
            oldest = awaited_responses.pop_front();
            if (rsp_out_voice !== oldest.voice)
               report_mismatch("out_voice", int'(rsp_out_voice), int'(oldest.voice));
            if (rsp_out_valid !== oldest.popped)
               report_mismatch("out_valid", int'(rsp_out_valid), int'(oldest.popped));
            if (rsp_dropped !== oldest.dropped)
               report_mismatch("dropped", int'(rsp_dropped), int'(oldest.dropped));
            if (rsp_occupancy !== oldest.occupancy)
               report_mismatch("occupancy", int'(rsp_occupancy), int'(oldest.occupancy));
         end
      end
   end

   initial begin
      stim_row_type                row;
      logic [fiq_pkg::OP_W-1:0]    op;
      logic [fiq_pkg::VOICE_W-1:0] voice;
      int                          phase_left;
      int                          enq_pct;
      int                          deq_pct;
      int                          rem_pct;
      int                          pool_base;
      int                          pool_span;
      int                          pick;

      // Directed table: empty-queue corner cases, run interleaving, a fill
      // to the top with drops, long passes on a full queue, and a drain.
      directed_rows.push_back(make_row(fiq_pkg::OP_DEQUEUE, 4'd0,  1, 0, 1,
                                       resp(0, 0, 0, 0)));
      directed_rows.push_back(make_row(fiq_pkg::OP_REMOVE,  4'd5,  1, 0, 1,
                                       resp(0, 0, 0, 0)));
      directed_rows.push_back(make_row(fiq_pkg::OP_CLEAR,   4'd15, 1, 0, 1,
                                       resp(0, 0, 0, 0)));
      directed_rows.push_back(make_row(fiq_pkg::OP_ENQUEUE, 4'd0,  1, 0, 1,
                                       resp(0, 0, 0, 1)));
      directed_rows.push_back(make_row(fiq_pkg::OP_ENQUEUE, 4'd15, 1, 0, 1,
                                       resp(0, 0, 0, 2)));
      directed_rows.push_back(make_row(fiq_pkg::OP_ENQUEUE, 4'd0,  1, 0, 0, '0));
      directed_rows.push_back(make_row(fiq_pkg::OP_ENQUEUE, 4'd15, 1, 0, 0, '0));
      directed_rows.push_back(make_row(fiq_pkg::OP_ENQUEUE, 4'd7,  1, 0, 0, '0));
      directed_rows.push_back(make_row(fiq_pkg::OP_DEQUEUE, 4'd9,  1, 0, 0, '0));
      directed_rows.push_back(make_row(fiq_pkg::OP_REMOVE,  4'd15, 1, 0, 0, '0));
      directed_rows.push_back(make_row(fiq_pkg::OP_REMOVE,  4'd9,  1, 0, 0, '0)); // absent voice
      directed_rows.push_back(make_row(fiq_pkg::OP_CLEAR,   4'd0,  1, 0, 1,
                                       resp(0, 0, 0, 0)));
      directed_rows.push_back(make_row(fiq_pkg::OP_ENQUEUE, 4'd3,  QUEUE_DEPTH, 1, 0, '0));
      directed_rows.push_back(make_row(fiq_pkg::OP_ENQUEUE, 4'd5,  1, 0, 1,
                                       resp(0, 0, 1, 32)));
      directed_rows.push_back(make_row(fiq_pkg::OP_ENQUEUE, 4'd10, 1, 0, 1,
                                       resp(0, 0, 1, 32)));
      directed_rows.push_back(make_row(fiq_pkg::OP_REMOVE,  4'd8,  1, 0, 0, '0));
      directed_rows.push_back(make_row(fiq_pkg::OP_ENQUEUE, 4'd8,  1, 0, 0, '0));
      directed_rows.push_back(make_row(fiq_pkg::OP_DEQUEUE, 4'd6,  1, 0, 0, '0));
      directed_rows.push_back(make_row(fiq_pkg::OP_ENQUEUE, 4'd12, 2, 0, 0, '0));
      directed_rows.push_back(make_row(fiq_pkg::OP_CLEAR,   4'd7,  1, 0, 1,
                                       resp(0, 0, 0, 0)));
      directed_rows.push_back(make_row(fiq_pkg::OP_ENQUEUE, 4'd6,  3, 0, 0, '0));
      directed_rows.push_back(make_row(fiq_pkg::OP_ENQUEUE, 4'd9,  3, 0, 0, '0));
      directed_rows.push_back(make_row(fiq_pkg::OP_DEQUEUE, 4'd0,  7, 0, 0, '0)); // last on empty

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         for (int k = 0; k < row.count; k++)
            send_request(row.op,
                         row.walk ? fiq_pkg::VOICE_W'(row.voice + k) : row.voice,
                         row.typed, row.want);
      end

      // Random traffic in phases. Fill phases push the queue to full and
      // into drops, drain phases empty it; a narrow voice pool builds many
      // repeats and therefore many runs, a wide one builds long runs.
      phase_left = 0;
      enq_pct = 0;
      deq_pct = 0;
      rem_pct = 0;
      pool_base = 0;
      pool_span = 16;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (phase_left == 0) begin
            phase_left = int'($urandom_range(20, 80));
            case ($urandom_range(0, 2))
               0: begin enq_pct = 72; deq_pct = 16; rem_pct = 10; end
               1: begin enq_pct = 25; deq_pct = 60; rem_pct = 12; end
               default: begin enq_pct = 46; deq_pct = 40; rem_pct = 12; end
            endcase
            pool_base = int'($urandom_range(0, 15));
            pool_span = ($urandom_range(0, 1) == 0) ? int'($urandom_range(1, 5)) : 16;
         end
         phase_left--;
         pick = int'($urandom_range(0, 99));
         if (pick < enq_pct)
            op = fiq_pkg::OP_ENQUEUE;
         else if (pick < enq_pct + deq_pct)
            op = fiq_pkg::OP_DEQUEUE;
         else if (pick < enq_pct + deq_pct + rem_pct)
            op = fiq_pkg::OP_REMOVE;
         else
            op = fiq_pkg::OP_CLEAR;
         voice = fiq_pkg::VOICE_W'(pool_base + int'($urandom_range(0, pool_span - 1)));
         send_request(op, voice, 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (awaited_responses.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("fair_interleave_request_queue_tb passed");
      else
         $display("fair_interleave_request_queue_tb failed");
      $finish;
   end

endmodule
